// File: rtl/core/antialiased_line_fragments_assert.svh
`ifndef ANTIALIASED_LINE_FRAGMENTS_ASSERT_SVH
`define ANTIALIASED_LINE_FRAGMENTS_ASSERT_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define ALF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, off while rst_ni is low.
`define ALF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/alf_pkg.sv
`default_nettype none

package alf_pkg;

  localparam int unsigned ALPHA_W = 9;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Y    = 3'd1,
    CFG_CLIP_LEFT   = 3'd2,
    CFG_CLIP_TOP    = 3'd3,
    CFG_CLIP_WIDTH  = 3'd4,
    CFG_CLIP_HEIGHT = 3'd5
  } cfg_idx_e;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [1:0] {
    OUT_STEP,
    OUT_POINT,
    OUT_EMPTY
  } out_sel_e;

  typedef struct packed {
    logic     load_start;
    logic     diff;
    logic     order;
    logic     div_step;
    logic     slope;
    logic     mul;
    logic     commit;
    logic     step;
    logic     load_out;
    out_sel_e out_sel;
  } alf_cmd_t;

  typedef struct packed {
    logic line_active;
    logic is_point;
    logic is_empty;
  } alf_status_t;

endpackage

`default_nettype wire

// File: rtl/core/alf_if.sv
`default_nettype none

interface alf_req_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [COORD_BITS-1:0]      start_x;
  logic signed [COORD_BITS-1:0]      start_y;
  logic signed [COORD_BITS-1:0]      end_x;
  logic signed [COORD_BITS-1:0]      end_y;
  logic [alf_pkg::ALPHA_W-1:0]       line_alpha;

  modport source (
    output valid, req_type, start_x, start_y, end_x, end_y, line_alpha,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_x, start_y, end_x, end_y, line_alpha,
    output ready
  );
endinterface

interface alf_rsp_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS:0]        near_x;
  logic signed [COORD_BITS:0]        near_y;
  logic [alf_pkg::ALPHA_W-1:0]       near_alpha;
  logic                              near_write;
  logic signed [COORD_BITS:0]        far_x;
  logic signed [COORD_BITS:0]        far_y;
  logic [alf_pkg::ALPHA_W-1:0]       far_alpha;
  logic                              far_write;
  logic                              last;

  modport source (
    output valid, near_x, near_y, near_alpha, near_write,
           far_x, far_y, far_alpha, far_write, last,
    input  ready
  );
  modport sink (
    input  valid, near_x, near_y, near_alpha, near_write,
           far_x, far_y, far_alpha, far_write, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/alf_ctrl.sv
`default_nettype none

module alf_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_type_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  input  alf_pkg::alf_status_t status_i,
  output alf_pkg::alf_cmd_t    cmd_o
);
  import alf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ORDER,
    ST_DIV,
    ST_SLOPE,
    ST_MUL,
    ST_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             accept;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.out_sel = OUT_STEP;
    state_d       = state_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_START) begin
            cmd_o.load_start = 1'b1;
            state_d          = ST_DIFF;
          end else if (status_i.line_active) begin
            cmd_o.step     = 1'b1;
            cmd_o.load_out = 1'b1;
            cmd_o.out_sel  = OUT_STEP;
            out_valid_d    = 1'b1;
          end
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_ORDER;
      end
      ST_ORDER: begin
        // output register is free here: a start is only taken when it is
        if (status_i.is_point) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = OUT_POINT;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.order = 1'b1;
          cnt_d       = '0;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_SLOPE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SLOPE: begin
        cmd_o.slope = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.commit = 1'b1;
        if (status_i.is_empty) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = OUT_EMPTY;
          out_valid_d    = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/alf_datapath.sv
`default_nettype none

module alf_datapath #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  alf_pkg::alf_cmd_t                cmd_i,
  output alf_pkg::alf_status_t             status_o,
  input  logic                             cfg_we_i,
  input  logic [alf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [COORD_BITS-1:0]            cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]     start_x_i,
  input  logic signed [COORD_BITS-1:0]     start_y_i,
  input  logic signed [COORD_BITS-1:0]     end_x_i,
  input  logic signed [COORD_BITS-1:0]     end_y_i,
  input  logic [alf_pkg::ALPHA_W-1:0]      line_alpha_i,
  output logic signed [COORD_BITS:0]       near_x_o,
  output logic signed [COORD_BITS:0]       near_y_o,
  output logic [alf_pkg::ALPHA_W-1:0]      near_alpha_o,
  output logic                             near_write_o,
  output logic signed [COORD_BITS:0]       far_x_o,
  output logic signed [COORD_BITS:0]       far_y_o,
  output logic [alf_pkg::ALPHA_W-1:0]      far_alpha_o,
  output logic                             far_write_o,
  output logic                             last_o
);
  import alf_pkg::*;

  localparam int unsigned PW  = COORD_BITS + 1;             // offset coordinate
  localparam int unsigned DW  = COORD_BITS + 2;             // differences, clip math
  localparam int unsigned LW  = COORD_BITS - 1;             // clip origin
  localparam int unsigned QW  = FRAC_BITS + 1;              // gradient magnitude
  localparam int unsigned SW  = FRAC_BITS + 2;              // signed gradient
  localparam int unsigned RW  = COORD_BITS + 2;             // divider remainder
  localparam int unsigned MW  = COORD_BITS + FRAC_BITS + 2; // minor position
  localparam int unsigned PRW = PW + 1 + SW;                // pre-clip product
  localparam int unsigned AW  = ALPHA_W;
  localparam logic [COORD_BITS-1:0] CLIP_SIZE_RST = {1'b1, {(COORD_BITS-1){1'b0}}};

  function automatic logic in_clip(input logic signed [DW-1:0] px,
                                   input logic signed [DW-1:0] py,
                                   input logic signed [DW-1:0] bx0,
                                   input logic signed [DW-1:0] bx1,
                                   input logic signed [DW-1:0] by0,
                                   input logic signed [DW-1:0] by1);
    return (px >= bx0) && (px < bx1) && (py >= by0) && (py < by1);
  endfunction

  // configuration
  logic signed [COORD_BITS-1:0] off_x_q, off_y_q;
  logic [LW-1:0]                clip_left_q, clip_top_q;
  logic [COORD_BITS-1:0]        clip_w_q, clip_h_q;

  // start setup
  logic signed [PW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [PW-1:0] m1_q, m2_q, n1_q;
  logic                 slope_neg_q;
  logic [PW-1:0]        div_d_q;
  logic [RW-1:0]        div_r_q;
  logic [QW-1:0]        div_q_q;
  logic [PW-1:0]        pre_diff_q;
  logic                 empty_q;
  logic signed [MW-1:0] prod_q;

  // line state
  logic                 line_active_q;
  logic                 major_x_q;
  logic signed [PW-1:0] major_now_q, major_stop_q;
  logic signed [MW-1:0] minor_q;
  logic signed [SW-1:0] slope_q;
  logic [AW-1:0]        alpha_q;

  // result register
  logic signed [PW-1:0] near_x_q, near_y_q, far_x_q, far_y_q;
  logic [AW-1:0]        near_alpha_q, far_alpha_q;
  logic                 near_write_q, far_write_q, last_q;

  logic signed [DW-1:0] cl_x0, cl_x1, cl_y0, cl_y1;
  logic signed [DW-1:0] abs_dx, abs_dy;
  logic [PW-1:0]        adx, ady;
  logic                 major_x, swap, minor_neg;
  logic                 div_ge;
  logic [RW-1:0]        div_sub;
  logic signed [DW-1:0] lo_s, lim_s, m1_s, m2_s, m1c, stopc, pre_diff_s;
  logic                 pre_clip;
  logic signed [PRW-1:0] prod_full;
  logic signed [DW-1:0] mi, mi1, maj_s;
  logic [FRAC_BITS-1:0] frac;
  logic [QW-1:0]        wgt;
  logic [QW+AW-1:0]     an_full;
  logic [AW-1:0]        an, af;
  logic signed [DW-1:0] nx, ny, fx, fy, px, py;
  logic                 fin;

  assign cl_x0 = $signed({{(DW-LW){1'b0}}, clip_left_q});
  assign cl_y0 = $signed({{(DW-LW){1'b0}}, clip_top_q});
  assign cl_x1 = cl_x0 + $signed({{(DW-COORD_BITS){1'b0}}, clip_w_q});
  assign cl_y1 = cl_y0 + $signed({{(DW-COORD_BITS){1'b0}}, clip_h_q});

  // axis pick and endpoint order
  assign abs_dx    = dx_q[DW-1] ? -dx_q : dx_q;
  assign abs_dy    = dy_q[DW-1] ? -dy_q : dy_q;
  assign adx       = abs_dx[PW-1:0];
  assign ady       = abs_dy[PW-1:0];
  assign major_x   = adx > ady;
  assign swap      = major_x ? dx_q[DW-1] : dy_q[DW-1];
  assign minor_neg = major_x ? dy_q[DW-1] : dx_q[DW-1];

  // one quotient bit per cycle
  assign div_ge  = div_r_q >= {1'b0, div_d_q};
  assign div_sub = div_ge ? (div_r_q - {1'b0, div_d_q}) : div_r_q;

  // pre-clip of the major range
  assign lo_s       = major_x_q ? cl_x0 : cl_y0;
  assign lim_s      = major_x_q ? cl_x1 : cl_y1;
  assign m1_s       = $signed({m1_q[PW-1], m1_q});
  assign m2_s       = $signed({m2_q[PW-1], m2_q});
  assign pre_clip   = m1_s < lo_s;
  assign m1c        = pre_clip ? lo_s : m1_s;
  assign stopc      = (m2_s >= lim_s) ? (lim_s - DW'(1)) : m2_s;
  assign pre_diff_s = lo_s - m1_s;
  assign prod_full  = $signed({1'b0, pre_diff_q}) * slope_q;

  // column emission
  assign mi      = minor_q[MW-1:FRAC_BITS];
  assign mi1     = mi + DW'(1);
  assign frac    = minor_q[FRAC_BITS-1:0];
  assign wgt     = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
  assign an_full = wgt * alpha_q;
  assign an      = an_full[FRAC_BITS +: AW];
  assign af      = alpha_q - an;
  assign maj_s   = $signed({major_now_q[PW-1], major_now_q});
  assign nx      = major_x_q ? maj_s : mi;
  assign ny      = major_x_q ? mi : maj_s;
  assign fx      = major_x_q ? maj_s : mi1;
  assign fy      = major_x_q ? mi1 : maj_s;
  assign fin     = major_now_q >= major_stop_q;
  assign px      = $signed({x1_q[PW-1], x1_q});
  assign py      = $signed({y1_q[PW-1], y1_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q     <= '0;
      off_y_q     <= '0;
      clip_left_q <= '0;
      clip_top_q  <= '0;
      clip_w_q    <= CLIP_SIZE_RST;
      clip_h_q    <= CLIP_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_X:    off_x_q     <= cfg_wdata_i;
        CFG_OFFSET_Y:    off_y_q     <= cfg_wdata_i;
        CFG_CLIP_LEFT:   clip_left_q <= cfg_wdata_i[LW-1:0];
        CFG_CLIP_TOP:    clip_top_q  <= cfg_wdata_i[LW-1:0];
        CFG_CLIP_WIDTH:  clip_w_q    <= cfg_wdata_i;
        CFG_CLIP_HEIGHT: clip_h_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
    end else if (cmd_i.load_start) begin
      line_active_q <= 1'b0;
    end else if (cmd_i.commit) begin
      line_active_q <= !empty_q;
    end else if (cmd_i.step && fin) begin
      line_active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      x1_q    <= $signed({start_x_i[COORD_BITS-1], start_x_i})
               + $signed({off_x_q[COORD_BITS-1], off_x_q});
      y1_q    <= $signed({start_y_i[COORD_BITS-1], start_y_i})
               + $signed({off_y_q[COORD_BITS-1], off_y_q});
      x2_q    <= $signed({end_x_i[COORD_BITS-1], end_x_i})
               + $signed({off_x_q[COORD_BITS-1], off_x_q});
      y2_q    <= $signed({end_y_i[COORD_BITS-1], end_y_i})
               + $signed({off_y_q[COORD_BITS-1], off_y_q});
      alpha_q <= (line_alpha_i > ALPHA_FULL) ? ALPHA_FULL : line_alpha_i;
    end
    if (cmd_i.diff) begin
      dx_q <= $signed({x2_q[PW-1], x2_q}) - $signed({x1_q[PW-1], x1_q});
      dy_q <= $signed({y2_q[PW-1], y2_q}) - $signed({y1_q[PW-1], y1_q});
    end
    if (cmd_i.order) begin
      major_x_q   <= major_x;
      m1_q        <= major_x ? (swap ? x2_q : x1_q) : (swap ? y2_q : y1_q);
      m2_q        <= major_x ? (swap ? x1_q : x2_q) : (swap ? y1_q : y2_q);
      n1_q        <= major_x ? (swap ? y2_q : y1_q) : (swap ? x2_q : x1_q);
      slope_neg_q <= minor_neg ^ swap;
      div_d_q     <= major_x ? adx : ady;
      div_r_q     <= {1'b0, (major_x ? ady : adx)};
      div_q_q     <= '0;
    end
    if (cmd_i.div_step) begin
      div_r_q <= {div_sub[RW-2:0], 1'b0};
      div_q_q <= {div_q_q[QW-2:0], div_ge};
    end
    if (cmd_i.slope) begin
      slope_q      <= slope_neg_q ? -$signed({1'b0, div_q_q}) : $signed({1'b0, div_q_q});
      pre_diff_q   <= pre_clip ? pre_diff_s[PW-1:0] : '0;
      empty_q      <= stopc < m1c;
      major_now_q  <= m1c[PW-1:0];
      major_stop_q <= stopc[PW-1:0];
    end else if (cmd_i.step) begin
      major_now_q <= major_now_q + PW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[MW-1:0];
    end
    if (cmd_i.commit) begin
      minor_q <= $signed({{(MW-PW-FRAC_BITS){n1_q[PW-1]}}, n1_q, {FRAC_BITS{1'b0}}})
               + prod_q;
    end else if (cmd_i.step) begin
      minor_q <= minor_q + $signed({{(MW-SW){slope_q[SW-1]}}, slope_q});
    end
    if (cmd_i.load_out) begin
      unique case (cmd_i.out_sel)
        OUT_STEP: begin
          near_x_q     <= nx[PW-1:0];
          near_y_q     <= ny[PW-1:0];
          near_alpha_q <= an;
          near_write_q <= in_clip(nx, ny, cl_x0, cl_x1, cl_y0, cl_y1);
          far_x_q      <= fx[PW-1:0];
          far_y_q      <= fy[PW-1:0];
          far_alpha_q  <= af;
          far_write_q  <= in_clip(fx, fy, cl_x0, cl_x1, cl_y0, cl_y1);
          last_q       <= fin;
        end
        OUT_POINT: begin
          near_x_q     <= x1_q;
          near_y_q     <= y1_q;
          near_alpha_q <= alpha_q;
          near_write_q <= in_clip(px, py, cl_x0, cl_x1, cl_y0, cl_y1);
          far_x_q      <= '0;
          far_y_q      <= '0;
          far_alpha_q  <= '0;
          far_write_q  <= 1'b0;
          last_q       <= 1'b1;
        end
        default: begin
          // empty line after clipping
          near_x_q     <= '0;
          near_y_q     <= '0;
          near_alpha_q <= '0;
          near_write_q <= 1'b0;
          far_x_q      <= '0;
          far_y_q      <= '0;
          far_alpha_q  <= '0;
          far_write_q  <= 1'b0;
          last_q       <= 1'b1;
        end
      endcase
    end
  end

  assign status_o.line_active = line_active_q;
  assign status_o.is_point    = (dx_q == '0) && (dy_q == '0);
  assign status_o.is_empty    = empty_q;

  assign near_x_o     = near_x_q;
  assign near_y_o     = near_y_q;
  assign near_alpha_o = near_alpha_q;
  assign near_write_o = near_write_q;
  assign far_x_o      = far_x_q;
  assign far_y_o      = far_y_q;
  assign far_alpha_o  = far_alpha_q;
  assign far_write_o  = far_write_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// File: rtl/core/antialiased_line_fragments.sv
// Antialiased line fragment generator, two pixels per major-axis column.
// req_i (sink) takes requests: req_type 0 starts a line from two endpoints
// and an alpha, req_type 1 steps to the next column. rsp_o (source) gives
// one fragment pair per step, plus one result for a point or a fully
// clipped line. cfg_we_i/cfg_idx_i/cfg_wdata_i write offset and clip
// registers; write them only while the block is idle.
// Step request: result registered on acceptance, valid in the next cycle;
// one step per cycle while rsp_o is taken. Start request: busy through the
// diff, order, divide (bit-serial, one quotient bit a cycle), slope, multiply
// and finish states; a point answers from the order state, skipping the rest.
// A request is accepted only when the output register is empty or being
// taken, so a stalled rsp_o holds its result and backs up into req_i.
// Steps while no line is active are taken and dropped; a start abandons any
// active line.
// Reset clears the line state and the output valid, and loads offsets 0,
// clip origin 0 and clip size 2^(COORD_BITS-1).
`default_nettype none

`include "antialiased_line_fragments_assert.svh"

module antialiased_line_fragments #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  alf_req_if.sink                       req_i,
  alf_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [alf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]         cfg_wdata_i
);
  import alf_pkg::*;

  alf_cmd_t    cmd;
  alf_status_t status;

  alf_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_type_i (req_i.req_type),
    .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  alf_datapath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_x_i   (req_i.start_x),
    .start_y_i   (req_i.start_y),
    .end_x_i     (req_i.end_x),
    .end_y_i     (req_i.end_y),
    .line_alpha_i(req_i.line_alpha),
    .near_x_o    (rsp_o.near_x),
    .near_y_o    (rsp_o.near_y),
    .near_alpha_o(rsp_o.near_alpha),
    .near_write_o(rsp_o.near_write),
    .far_x_o     (rsp_o.far_x),
    .far_y_o     (rsp_o.far_y),
    .far_alpha_o (rsp_o.far_alpha),
    .far_write_o (rsp_o.far_write),
    .last_o      (rsp_o.last)
  );

  `ALF_ASSERT_IMP(a_req_no_overrun, req_i.valid && req_i.ready, !rsp_o.valid || rsp_o.ready, "request taken over a stalled result")
  `ALF_ASSERT_IMP(a_last_ends_line, rsp_o.valid && rsp_o.last, !status.line_active, "line still active behind its last column")
  `ALF_ASSERT_IMP(a_alpha_split, rsp_o.valid, (10'(rsp_o.near_alpha) + 10'(rsp_o.far_alpha)) <= 10'(ALPHA_FULL), "split alpha exceeds full opacity")
  `ALF_ASSERT_NXT(a_step_emits, req_i.valid && req_i.ready && (req_i.req_type == REQ_STEP) && status.line_active, rsp_o.valid, "active step gave no result")

endmodule

`default_nettype wire
